[hdl/trlpd_pkg.sv]
package trlpd_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // pixel_format codes
  localparam logic [2:0] FMT_GREY8  = 3'd0;
  localparam logic [2:0] FMT_INDEX8 = 3'd1;
  localparam logic [2:0] FMT_TRUE16 = 3'd2;
  localparam logic [2:0] FMT_TRUE24 = 3'd3;
  localparam logic [2:0] FMT_TRUE32 = 3'd4;

  // palette_entry_format codes
  localparam logic [1:0] PAL_FMT_16 = 2'd0;
  localparam logic [1:0] PAL_FMT_24 = 2'd1;
  localparam logic [1:0] PAL_FMT_32 = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_PIXEL_FORMAT   = 2'd0;
  localparam logic [1:0] CFG_PALETTE_FORMAT = 2'd1;
  localparam logic [1:0] CFG_RUN_LENGTH     = 2'd2;
  localparam logic [1:0] CFG_PIXEL_COUNT    = 2'd3;

  // operation codes
  localparam logic OP_IMAGE_BYTE    = 1'b0;
  localparam logic OP_PALETTE_WRITE = 1'b1;

  localparam logic [15:0] MASK_B5 = 16'h001F;
  localparam logic [15:0] MASK_G5 = 16'h03E0;
  localparam logic [15:0] MASK_R5 = 16'h7C00;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [31:0] palette_value;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_done;
    logic       overrun_error;
  } pixel_out_t;

  typedef struct packed {
    logic [2:0]  pixel_format;
    logic [1:0]  palette_entry_format;
    logic        run_length_coded;
    logic [31:0] pixel_count;
  } cfg_t;

  // result of one pixel leaving the stream parser
  typedef struct packed {
    logic        valid;
    logic [31:0] colour;
    logic        use_palette;
    logic        palette_miss;
    logic [7:0]  repeat_count;
    logic        image_done;
    logic        overrun_error;
  } pix_result_t;

  function automatic logic [31:0] widen16(input logic [15:0] v);
    logic [15:0] b;
    logic [15:0] g;
    logic [15:0] r;
    b = (v & MASK_B5) << 3;
    g = (v & MASK_G5) >> 2;
    r = (v & MASK_R5) >> 7;
    return {8'h00, r[7:0], g[7:0], b[7:0]};
  endfunction

endpackage

[hdl/trlpd_palette.sv]
module trlpd_palette (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [7:0]                wr_index,
  input  logic [31:0]               wr_value,
  input  logic [1:0]                entry_format,
  input  logic                      rd_en,
  input  logic [trlpd_pkg::PAL_AW-1:0] rd_addr,
  output logic [31:0]               rd_data
);
  import trlpd_pkg::*;

  logic [31:0] mem [PALETTE_DEPTH];
  logic [31:0] wide_value;
  logic        wr_in_range;

  always_comb begin
    case (entry_format)
      PAL_FMT_16: wide_value = widen16(wr_value[15:0]);
      PAL_FMT_24: wide_value = {8'h00, wr_value[23:0]};
      default:    wide_value = wr_value;
    endcase
    wr_in_range = ({1'b0, wr_index} < 9'(PALETTE_DEPTH));
  end

  // widen on write, so a read returns a finished colour
  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_index[PAL_AW-1:0]] <= wide_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/trlpd_stream.sv]
module trlpd_stream (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  trlpd_pkg::pixel_in_t         item,
  input  trlpd_pkg::cfg_t              cfg,
  output trlpd_pkg::pix_result_t       result,
  output logic                         rd_en,
  output logic [trlpd_pkg::PAL_AW-1:0] rd_addr
);
  import trlpd_pkg::*;

  logic [7:0]  packet_left;
  logic        packet_is_run;
  logic [1:0]  byte_phase;
  logic [31:0] partial_pixel;
  logic [31:0] pixels_done;

  logic [7:0]  packet_left_next;
  logic        packet_is_run_next;
  logic [1:0]  byte_phase_next;
  logic [31:0] partial_pixel_next;
  logic [31:0] pixels_done_next;

  logic        is_header;
  logic [31:0] assembled;
  logic [2:0]  phase_inc;
  logic [2:0]  bytes_per_pixel;
  logic [31:0] remaining;
  logic [7:0]  count;
  logic [7:0]  left_dec;
  logic [7:0]  rep;
  logic        over;
  logic        done;

  always_comb begin
    case (cfg.pixel_format)
      FMT_GREY8, FMT_INDEX8: bytes_per_pixel = 3'd1;
      FMT_TRUE16:            bytes_per_pixel = 3'd2;
      FMT_TRUE24:            bytes_per_pixel = 3'd3;
      default:               bytes_per_pixel = 3'd4;
    endcase

    packet_left_next   = packet_left;
    packet_is_run_next = packet_is_run;
    byte_phase_next    = byte_phase;
    partial_pixel_next = partial_pixel;
    pixels_done_next   = pixels_done;

    is_header = cfg.run_length_coded && (packet_left == 8'd0);
    assembled = partial_pixel | ({24'h0, item.data_byte} << {byte_phase, 3'b000});
    phase_inc = {1'b0, byte_phase} + 3'd1;

    remaining = (cfg.pixel_count > pixels_done) ? (cfg.pixel_count - pixels_done) : 32'd1;
    left_dec  = packet_left - 8'd1;
    count     = (cfg.run_length_coded && packet_is_run) ? packet_left : 8'd1;
    over      = cfg.run_length_coded && !packet_is_run && (remaining == 32'd1) &&
                (left_dec != 8'd0);
    rep       = count;
    if ({24'h0, count} > remaining) begin
      rep  = remaining[7:0];
      over = 1'b1;
    end
    done = ({24'h0, rep} == remaining);

    result              = '0;
    result.colour       = assembled;
    result.repeat_count = rep;
    result.image_done   = done;
    result.overrun_error = over;
    rd_en   = 1'b0;
    rd_addr = assembled[PAL_AW-1:0];

    case (cfg.pixel_format)
      FMT_GREY8:  result.colour = {8'h00, assembled[7:0], assembled[7:0], assembled[7:0]};
      FMT_INDEX8: result.colour = '0;
      FMT_TRUE16: result.colour = widen16(assembled[15:0]);
      FMT_TRUE24: result.colour = {8'h00, assembled[23:0]};
      default:    result.colour = assembled;
    endcase
    result.use_palette  = (cfg.pixel_format == FMT_INDEX8);
    result.palette_miss = ({1'b0, assembled[7:0]} >= 9'(PALETTE_DEPTH));

    if (accept && item.operation == OP_IMAGE_BYTE) begin
      if (is_header) begin
        packet_is_run_next = item.data_byte[7];
        packet_left_next   = {1'b0, item.data_byte[6:0]} + 8'd1;
        byte_phase_next    = '0;
        partial_pixel_next = '0;
      end else if (phase_inc < bytes_per_pixel) begin
        byte_phase_next    = phase_inc[1:0];
        partial_pixel_next = assembled;
      end else begin
        result.valid       = 1'b1;
        rd_en              = result.use_palette && !result.palette_miss;
        byte_phase_next    = '0;
        partial_pixel_next = '0;
        if (cfg.run_length_coded) begin
          packet_left_next = packet_is_run ? 8'd0 : left_dec;
        end
        if (done) begin
          pixels_done_next   = '0;
          packet_left_next   = '0;
          packet_is_run_next = 1'b0;
        end else begin
          pixels_done_next = pixels_done + {24'h0, rep};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_left   <= '0;
      packet_is_run <= 1'b0;
      byte_phase    <= '0;
      partial_pixel <= '0;
      pixels_done   <= '0;
    end else begin
      packet_left   <= packet_left_next;
      packet_is_run <= packet_is_run_next;
      byte_phase    <= byte_phase_next;
      partial_pixel <= partial_pixel_next;
      pixels_done   <= pixels_done_next;
    end
  end

endmodule

[hdl/tga_rle_pixel_decoder.sv]
// TGA run-length pixel decoder. Feed the image data stream one byte per word
// (operation 0) and palette entries one entry per word (operation 1); pixels
// come out as blue, green, red and alpha with a repeat count, one word per
// run packet or per raw pixel. The block takes one input word every cycle
// unless the output stalls with a pixel pending. A finished pixel goes to
// the pending stage, which waits for the synchronous read of the 256-entry
// palette memory, then to the output register. Headers, incomplete pixels
// and palette writes give no output. Palette entries widen on write using the
// palette format in force then. Write configuration only while idle.
module tga_rle_pixel_decoder (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  trlpd_pkg::pixel_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output trlpd_pkg::pixel_out_t out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import trlpd_pkg::*;

  cfg_t                cfg;
  pix_result_t         res;
  pix_result_t         pend;
  logic                pend_valid;
  logic                accept;
  logic                out_free;
  logic                rd_en;
  logic [PAL_AW-1:0]   rd_addr;
  logic [31:0]         rd_data;
  logic [31:0]         colour;

  assign cfg_ready = 1'b1;

  // Hold a finished pixel in the output register while the next word moves
  // into the pending stage, which waits there for the palette read data.
  assign out_free = !out_valid || out_ready;
  assign in_ready = !pend_valid || out_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format         <= FMT_TRUE24;
      cfg.palette_entry_format <= PAL_FMT_24;
      cfg.run_length_coded     <= 1'b0;
      cfg.pixel_count          <= 32'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PIXEL_FORMAT:   cfg.pixel_format         <= cfg_data[2:0];
        CFG_PALETTE_FORMAT: cfg.palette_entry_format <= cfg_data[1:0];
        CFG_RUN_LENGTH:     cfg.run_length_coded     <= cfg_data[0];
        CFG_PIXEL_COUNT:    cfg.pixel_count          <= cfg_data;
        default: ;
      endcase
    end
  end

  trlpd_stream u_stream (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (in_data),
    .cfg     (cfg),
    .result  (res),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  // Read only on an accepted palette pixel so the data holds while stalled.
  trlpd_palette u_palette (
    .clk          (clk),
    .wr_en        (accept && in_data.operation == OP_PALETTE_WRITE),
    .wr_index     (in_data.palette_index),
    .wr_value     (in_data.palette_value),
    .entry_format (cfg.palette_entry_format),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  // Pending stage: valid flag cleared on reset, payload unreset.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept && res.valid) begin
      pend_valid <= 1'b1;
    end else if (out_free) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      pend <= res;
    end
  end

  // Pick the palette colour once its read data is in; an index past the
  // palette depth reads as black.
  always_comb begin
    if (pend.use_palette) begin
      colour = pend.palette_miss ? 32'h0 : rd_data;
    end else begin
      colour = pend.colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend_valid) begin
      out_data.blue          <= colour[7:0];
      out_data.green         <= colour[15:8];
      out_data.red           <= colour[23:16];
      out_data.alpha         <= colour[31:24];
      out_data.repeat_count  <= pend.repeat_count;
      out_data.image_done    <= pend.image_done;
      out_data.overrun_error <= pend.overrun_error;
    end
  end

`ifndef SYNTHESIS
  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.repeat_count != 8'd0))
    else $error("repeat count of zero on output");

  a_over_ends_image: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.overrun_error || out_data.image_done))
    else $error("overrun flagged without image end");

  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !out_free) |=> pend_valid)
    else $error("pending pixel lost while output stalled");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (pend_valid && out_valid))
    else $error("input stalled with a free stage");

  a_no_read_stalled: assert property (@(posedge clk) disable iff (rst)
    (pend_valid && !out_free) |-> !rd_en)
    else $error("palette read while pending data still needed");
`endif

endmodule
